// ===== design/rwc_pkg.sv =====
// rwc_pkg: widths, types and structs shared by the rolling correlation block
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package rwc_pkg;

  // window geometry
  localparam int MAX_WINDOW = 32;
  localparam int CFG_W      = 6;
  localparam int N_W        = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W     = $clog2(MAX_WINDOW);

  // sample and running sum widths
  localparam int SAMPLE_W = 16;
  localparam int SX_W     = 22;
  localparam int SXY_W    = 37;
  localparam int SXX_W    = 36;

  // correlation arithmetic widths
  localparam int COV_W   = 44;
  localparam int VAR_W   = 42;
  localparam int RAD_W   = 82;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = 44;
  localparam int CS_W    = REM_W + 2;
  localparam int Q_W     = 15;
  localparam int CORR_W  = 16;
  localparam int Q_ONE   = 16384;

  // shared multiplier
  localparam int MUL_A_W = 42;
  localparam int MUL_B_W = 23;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [CORR_W-1:0]   corr_t;

  // request and response of the shared compare/subtract unit
  typedef struct packed {
    logic [CS_W-1:0] a;
    logic [CS_W-1:0] b;
  } cs_req_t;

  typedef struct packed {
    logic [CS_W-1:0] diff;
    logic            ge;
  } cs_rsp_t;

endpackage

`default_nettype wire

// ===== design/rwc_if.sv =====
// rwc_if: valid/ready channel interfaces for sample input, result output and config
// depends on rwc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rwc_in_if;
  import rwc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t x_sample;
  sample_t y_sample;
  logic    series_start;
  modport source (output valid, output x_sample, output y_sample, output series_start,
                  input ready);
  modport sink (input valid, input x_sample, input y_sample, input series_start,
                output ready);
endinterface

interface rwc_out_if;
  import rwc_pkg::*;
  logic  valid;
  logic  ready;
  corr_t correlation;
  logic  window_full;
  modport source (output valid, output correlation, output window_full, input ready);
  modport sink (input valid, input correlation, input window_full, output ready);
endinterface

interface rwc_cfg_if;
  import rwc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] window_length;
  modport source (output valid, output window_length, input ready);
  modport sink (input valid, input window_length, output ready);
endinterface

`default_nettype wire

// ===== design/rwc_ram.sv =====
// rwc_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/rwc_mul.sv =====
// rwc_mul: shared signed multiplier with registered product
// depends on rwc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rwc_mul (
  input  wire logic                                clk,
  input  wire logic signed [rwc_pkg::MUL_A_W-1:0] op_a,
  input  wire logic signed [rwc_pkg::MUL_B_W-1:0] op_b,
  output logic signed      [rwc_pkg::PROD_W-1:0]  prod_r
);
  import rwc_pkg::*;

  // one product per cycle, consumed the cycle after
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

`default_nettype wire

// ===== design/rwc_cmpsub.sv =====
// rwc_cmpsub: shared compare and subtract step for the square root and the divider
// depends on rwc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rwc_cmpsub (
  input  wire rwc_pkg::cs_req_t req,
  output rwc_pkg::cs_rsp_t      rsp
);
  import rwc_pkg::*;

  logic [CS_W:0] wide_diff;

  // borrow out of the subtraction tells whether a >= b
  always_comb begin
    wide_diff = {1'b0, req.a} - {1'b0, req.b};
    rsp.diff  = wide_diff[CS_W-1:0];
    rsp.ge    = ~wide_diff[CS_W];
  end

endmodule

`default_nettype wire

// ===== design/rolling_window_correlation.sv =====
// Rolling Pearson correlation over a sliding window of sample pairs.
// One pair at a time: input is ready only while idle, so a new pair waits for the
// previous result to reach the output register. With a full window the sequence runs
// 14 shared multiplies, then a 41-step square root and a 15-step divide sharing one
// compare/subtract unit; a filling window or a zero variance ends early with zero.
// Reset: rst_n synchronous active low; window length 5, sums and fill state cleared.
// depends on rwc_pkg, rwc_if, rwc_ram, rwc_mul, rwc_cmpsub
`timescale 1ns / 1ps
`default_nettype none

module rolling_window_correlation (
  input  wire logic clk,
  input  wire logic rst_n,
  rwc_in_if.sink    in_ch,
  rwc_out_if.source out_ch,
  rwc_cfg_if.sink   cfg_ch
);
  import rwc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_SQRT = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    OP_XY, OP_XX, OP_YY, OP_OXY, OP_OXX, OP_OYY,
    OP_NXX, OP_SXX, OP_NYY, OP_SYY, OP_NXY, OP_SXY,
    OP_VLO, OP_VHI
  } mul_op_t;

  localparam int STEP_W    = $clog2(ROOT_W);
  localparam int MUL_OPS   = 14;
  localparam int VHI_SHIFT = MUL_B_W - 1;
  localparam int HIST_W    = 2 * SAMPLE_W;

  function automatic logic [N_W-1:0] clamp_window(input logic [CFG_W-1:0] v);
    logic [N_W-1:0] res;
    if (int'(v) < 2) begin
      res = N_W'(2);
    end else if (int'(v) > MAX_WINDOW) begin
      res = N_W'(MAX_WINDOW);
    end else begin
      res = N_W'(v);
    end
    return res;
  endfunction

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [N_W-1:0] n_r, n_nxt, fill_r, fill_nxt;
  logic [SLOT_W-1:0] wslot_r, wslot_nxt, slot_r, slot_nxt;
  sample_t x_r, x_nxt, y_r, y_nxt, ox_r, ox_nxt, oy_r, oy_nxt;
  logic signed [SX_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [SXY_W-1:0] sxy_r, sxy_nxt;
  logic signed [SXX_W-1:0] sxx_r, sxx_nxt, syy_r, syy_nxt;
  logic signed [COV_W-1:0] cov_r, cov_nxt;
  logic signed [VAR_W-1:0] va_r, va_nxt, vb_r, vb_nxt;
  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [Q_W-1:0] q_r, q_nxt;
  logic evict_r, evict_nxt, full_r, full_nxt, zero_r, zero_nxt;
  logic acc_vld_r, acc_vld_nxt;
  mul_op_t acc_op_r, acc_op_nxt;
  logic out_vld_r, out_vld_nxt, out_full_r, out_full_nxt;
  corr_t out_corr_r, out_corr_nxt;

  logic in_xfer, cfg_xfer;
  logic [SLOT_W-1:0] ws_eff, slot_sel;
  logic [N_W-1:0] fill_eff, slot_inc, fill_inc;
  logic ram_we;
  logic [HIST_W-1:0] ram_rdata;
  sample_t ram_ox, ram_oy;
  mul_op_t issue_op;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  cs_req_t cs_req;
  cs_rsp_t cs_rsp;
  logic [COV_W-1:0] cov_abs;
  logic [Q_W-1:0] q_sat;

  // handshakes, a pending config write holds off the input
  assign in_ch.ready  = (state_r == ST_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == ST_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_xfer     = cfg_ch.valid && cfg_ch.ready;

  assign out_ch.valid       = out_vld_r;
  assign out_ch.correlation = out_corr_r;
  assign out_ch.window_full = out_full_r;

  // ring slot for the incoming pair
  always_comb begin
    ws_eff   = in_ch.series_start ? '0 : wslot_r;
    fill_eff = in_ch.series_start ? '0 : fill_r;
    slot_sel = (N_W'(ws_eff) >= n_r) ? '0 : ws_eff;
    slot_inc = N_W'(slot_sel) + N_W'(1);
    fill_inc = (fill_eff < n_r) ? fill_eff + N_W'(1) : fill_eff;
  end

  // sample history, x in the upper half
  assign ram_we = (state_r == ST_LOAD);

  rwc_ram #(
    .WIDTH (HIST_W),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata ({x_r, y_r}),
    .re    (in_xfer),
    .raddr (slot_sel),
    .rdata (ram_rdata)
  );

  assign ram_ox = $signed(ram_rdata[HIST_W-1:SAMPLE_W]);
  assign ram_oy = $signed(ram_rdata[SAMPLE_W-1:0]);

  // multiplier operand selection, one op per sequencer step
  assign issue_op = mul_op_t'(step_r[3:0]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_MUL) begin
      unique case (issue_op)
        OP_XY:  begin mul_a = MUL_A_W'(x_r);   mul_b = MUL_B_W'(y_r);   end
        OP_XX:  begin mul_a = MUL_A_W'(x_r);   mul_b = MUL_B_W'(x_r);   end
        OP_YY:  begin mul_a = MUL_A_W'(y_r);   mul_b = MUL_B_W'(y_r);   end
        OP_OXY: begin mul_a = MUL_A_W'(ox_r);  mul_b = MUL_B_W'(oy_r);  end
        OP_OXX: begin mul_a = MUL_A_W'(ox_r);  mul_b = MUL_B_W'(ox_r);  end
        OP_OYY: begin mul_a = MUL_A_W'(oy_r);  mul_b = MUL_B_W'(oy_r);  end
        OP_NXX: begin mul_a = MUL_A_W'(sxx_r); mul_b = $signed(MUL_B_W'(n_r)); end
        OP_SXX: begin mul_a = MUL_A_W'(sx_r);  mul_b = MUL_B_W'(sx_r);  end
        OP_NYY: begin mul_a = MUL_A_W'(syy_r); mul_b = $signed(MUL_B_W'(n_r)); end
        OP_SYY: begin mul_a = MUL_A_W'(sy_r);  mul_b = MUL_B_W'(sy_r);  end
        OP_NXY: begin mul_a = MUL_A_W'(sxy_r); mul_b = $signed(MUL_B_W'(n_r)); end
        OP_SXY: begin mul_a = MUL_A_W'(sx_r);  mul_b = MUL_B_W'(sy_r);  end
        OP_VLO: begin
          mul_a = MUL_A_W'(va_r);
          mul_b = $signed(MUL_B_W'(vb_r[VHI_SHIFT-1:0]));
        end
        OP_VHI: begin
          mul_a = MUL_A_W'(va_r);
          mul_b = $signed(MUL_B_W'(vb_r[VAR_W-1:VHI_SHIFT]));
        end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  rwc_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  // shared compare/subtract: root trial in sqrt, divisor in divide
  always_comb begin
    cs_req = '0;
    if (state_r == ST_SQRT) begin
      cs_req.a = {rem_r, rad_r[RAD_W-1 -: 2]};
      cs_req.b = CS_W'({root_r, 2'b01});
    end else if (state_r == ST_DIV) begin
      cs_req.a = (step_r == '0) ? CS_W'(rem_r) : CS_W'({rem_r, 1'b0});
      cs_req.b = CS_W'(root_r);
    end
  end

  rwc_cmpsub u_cmpsub (
    .req (cs_req),
    .rsp (cs_rsp)
  );

  assign cov_abs = cov_r[COV_W-1] ? COV_W'(-cov_r) : COV_W'(cov_r);
  assign q_sat   = (int'(q_r) > Q_ONE) ? Q_W'(Q_ONE) : q_r;

  // sequencer and datapath next state
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    n_nxt        = n_r;
    fill_nxt     = fill_r;
    wslot_nxt    = wslot_r;
    slot_nxt     = slot_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    sx_nxt       = sx_r;
    sy_nxt       = sy_r;
    sxy_nxt      = sxy_r;
    sxx_nxt      = sxx_r;
    syy_nxt      = syy_r;
    cov_nxt      = cov_r;
    va_nxt       = va_r;
    vb_nxt       = vb_r;
    rad_nxt      = rad_r;
    rem_nxt      = rem_r;
    root_nxt     = root_r;
    q_nxt        = q_r;
    evict_nxt    = evict_r;
    full_nxt     = full_r;
    zero_nxt     = zero_r;
    acc_vld_nxt  = 1'b0;
    acc_op_nxt   = issue_op;
    out_vld_nxt  = out_vld_r;
    out_corr_nxt = out_corr_r;
    out_full_nxt = out_full_r;

    // result register drains independently
    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    // accumulate the product issued last cycle
    if (acc_vld_r) begin
      unique case (acc_op_r)
        OP_XY:  sxy_nxt = sxy_r + $signed(prod[SXY_W-1:0]);
        OP_XX:  sxx_nxt = sxx_r + $signed(prod[SXX_W-1:0]);
        OP_YY:  syy_nxt = syy_r + $signed(prod[SXX_W-1:0]);
        OP_OXY: if (evict_r) begin sxy_nxt = sxy_r - $signed(prod[SXY_W-1:0]); end
        OP_OXX: if (evict_r) begin sxx_nxt = sxx_r - $signed(prod[SXX_W-1:0]); end
        OP_OYY: if (evict_r) begin syy_nxt = syy_r - $signed(prod[SXX_W-1:0]); end
        OP_NXX: va_nxt = $signed(prod[VAR_W-1:0]);
        OP_SXX: va_nxt = va_r - $signed(prod[VAR_W-1:0]);
        OP_NYY: vb_nxt = $signed(prod[VAR_W-1:0]);
        OP_SYY: vb_nxt = vb_r - $signed(prod[VAR_W-1:0]);
        OP_NXY: cov_nxt = $signed(prod[COV_W-1:0]);
        OP_SXY: cov_nxt = cov_r - $signed(prod[COV_W-1:0]);
        OP_VLO: rad_nxt = RAD_W'(prod[PROD_W-2:0]);
        OP_VHI: rad_nxt = rad_r + {prod[RAD_W-VHI_SHIFT-1:0], VHI_SHIFT'(0)};
        default: begin end
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_xfer) begin
          n_nxt     = clamp_window(cfg_ch.window_length);
          fill_nxt  = '0;
          wslot_nxt = '0;
          sx_nxt    = '0;
          sy_nxt    = '0;
          sxy_nxt   = '0;
          sxx_nxt   = '0;
          syy_nxt   = '0;
        end else if (in_xfer) begin
          x_nxt     = in_ch.x_sample;
          y_nxt     = in_ch.y_sample;
          slot_nxt  = slot_sel;
          evict_nxt = (fill_eff >= n_r);
          fill_nxt  = fill_inc;
          full_nxt  = (fill_inc >= n_r);
          wslot_nxt = (slot_inc >= n_r) ? '0 : slot_inc[SLOT_W-1:0];
          if (in_ch.series_start) begin
            sx_nxt  = '0;
            sy_nxt  = '0;
            sxy_nxt = '0;
            sxx_nxt = '0;
            syy_nxt = '0;
          end
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // linear sums take the new pair and drop the evicted one
        ox_nxt    = ram_ox;
        oy_nxt    = ram_oy;
        sx_nxt    = sx_r + SX_W'(x_r) - (evict_r ? SX_W'(ram_ox) : SX_W'(0));
        sy_nxt    = sy_r + SX_W'(y_r) - (evict_r ? SX_W'(ram_oy) : SX_W'(0));
        zero_nxt  = 1'b0;
        step_nxt  = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(OP_NXX) && !full_r) begin
          // window still filling: result is zero
          zero_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else if (step_r == STEP_W'(MUL_OPS)) begin
          step_nxt = '0;
          rem_nxt  = '0;
          root_nxt = '0;
          if (va_r <= 0 || vb_r <= 0) begin
            zero_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SQRT;
          end
        end else begin
          acc_vld_nxt = 1'b1;
        end
      end
      ST_SQRT: begin
        // one root bit per cycle, two radicand bits shifted in
        root_nxt = {root_r[ROOT_W-2:0], cs_rsp.ge};
        rem_nxt  = cs_rsp.ge ? cs_rsp.diff[REM_W-1:0] : cs_req.a[REM_W-1:0];
        rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          rem_nxt   = REM_W'(cov_abs);
          q_nxt     = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring divide of |cov| * 2^14 by the root, one quotient bit per cycle
        q_nxt    = {q_r[Q_W-2:0], cs_rsp.ge};
        rem_nxt  = cs_rsp.ge ? cs_rsp.diff[REM_W-1:0] : cs_req.a[REM_W-1:0];
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(Q_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt  = 1'b1;
          out_full_nxt = full_r;
          if (zero_r) begin
            out_corr_nxt = '0;
          end else if (cov_r[COV_W-1]) begin
            out_corr_nxt = -corr_t'(q_sat);
          end else begin
            out_corr_nxt = corr_t'(q_sat);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= '0;
      n_r       <= N_W'(5);
      fill_r    <= '0;
      wslot_r   <= '0;
      sx_r      <= '0;
      sy_r      <= '0;
      sxy_r     <= '0;
      sxx_r     <= '0;
      syy_r     <= '0;
      acc_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      n_r       <= n_nxt;
      fill_r    <= fill_nxt;
      wslot_r   <= wslot_nxt;
      sx_r      <= sx_nxt;
      sy_r      <= sy_nxt;
      sxy_r     <= sxy_nxt;
      sxx_r     <= sxx_nxt;
      syy_r     <= syy_nxt;
      acc_vld_r <= acc_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    ox_r       <= ox_nxt;
    oy_r       <= oy_nxt;
    cov_r      <= cov_nxt;
    va_r       <= va_nxt;
    vb_r       <= vb_nxt;
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    q_r        <= q_nxt;
    evict_r    <= evict_nxt;
    full_r     <= full_nxt;
    zero_r     <= zero_nxt;
    acc_op_r   <= acc_op_nxt;
    out_corr_r <= out_corr_nxt;
    out_full_r <= out_full_nxt;
  end

  // fill count never passes the window length
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= n_r)
    else $error("fill count beyond window length");

  // next write slot stays inside the window
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    N_W'(wslot_r) < n_r)
    else $error("write slot outside window");

  // a result from a partial window carries zero correlation
  a_partial_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_full_r |-> out_corr_r == '0)
    else $error("nonzero correlation before window full");

  // correlation stays within plus or minus one
  a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ($signed(out_corr_r) <= 16384 && $signed(out_corr_r) >= -16384))
    else $error("correlation out of range");

  // an input transfer always starts with the history read cycle
  a_xfer_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !cfg_xfer |=> state_r == ST_LOAD)
    else $error("input transfer did not start the sequence");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// testbench: checks rolling_window_correlation against a built-in window predictor,
// driving directed and random sample pairs under random idling and several window lengths
// depends on rwc_pkg, rwc_if and the rolling_window_correlation rtl
`timescale 1ns / 1ps

module testbench;
  import rwc_pkg::*;

  localparam int HALF_PERIOD      = 4;
  localparam int RESET_CYCLES     = 8;
  localparam int SETTLE_CYCLES    = 80;
  localparam int HOLD_CYCLES      = 600;
  localparam int RANDOM_PER_PHASE = 160;
  localparam int RUN_LIMIT_NS     = 8_000_000;

  // window lengths written between phases, random ones follow
  localparam int LISTED_PHASES = 7;
  localparam int EXTRA_PHASES  = 3;
  localparam logic [CFG_W-1:0] PHASE_WINDOWS [LISTED_PHASES] =
    '{6'd2, 6'd32, 6'd0, 6'd63, 6'd1, 6'd33, 6'd17};
  localparam int HOLD_PHASE = 1;

  typedef struct packed {
    corr_t correlation;
    logic  window_full;
  } corr_result_t;

  typedef struct packed {
    sample_t x;
    sample_t y;
    logic    start;
    logic    known;
    corr_t   corr;
    logic    full;
  } stim_row_t;

  typedef enum int {
    MIX_RANDOM,
    MIX_TRACKING,
    MIX_FLAT_X,
    MIX_FLAT_Y,
    MIX_TINY,
    MIX_RAILS
  } series_shape_e;

  // directed pairs, run at the reset window length of 5
  localparam int DIRECTED_COUNT = 24;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // window filling after reset
    '{-32768,  32767, 1'b1, 1'b1, 16'sd0, 1'b0},
    '{ 32767, -32768, 1'b0, 1'b1, 16'sd0, 1'b0},
    '{     0,      0, 1'b0, 1'b1, 16'sd0, 1'b0},
    '{    -1,      1, 1'b0, 1'b1, 16'sd0, 1'b0},
    '{     1,     -1, 1'b0, 1'b0, 16'sd0, 1'b0},
    // rail values sliding through the ring
    '{ 32767, -32768, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{-32768,  32767, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{ 32767,  32767, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{-32768, -32768, 1'b0, 1'b0, 16'sd0, 1'b0},
    // constant x: zero denominator
    '{   100,      1, 1'b1, 1'b1, 16'sd0, 1'b0},
    '{   100,      2, 1'b0, 1'b1, 16'sd0, 1'b0},
    '{   100,      3, 1'b0, 1'b1, 16'sd0, 1'b0},
    '{   100,      4, 1'b0, 1'b1, 16'sd0, 1'b0},
    '{   100,      5, 1'b0, 1'b1, 16'sd0, 1'b1},
    // y tracks x exactly
    '{     1,      1, 1'b1, 1'b1, 16'sd0, 1'b0},
    '{     2,      2, 1'b0, 1'b1, 16'sd0, 1'b0},
    '{     3,      3, 1'b0, 1'b1, 16'sd0, 1'b0},
    '{     4,      4, 1'b0, 1'b1, 16'sd0, 1'b0},
    '{     5,      5, 1'b0, 1'b1, corr_t'(Q_ONE), 1'b1},
    // y mirrors x
    '{     1,     -1, 1'b1, 1'b1, 16'sd0, 1'b0},
    '{     2,     -2, 1'b0, 1'b1, 16'sd0, 1'b0},
    '{     3,     -3, 1'b0, 1'b1, 16'sd0, 1'b0},
    '{     4,     -4, 1'b0, 1'b1, 16'sd0, 1'b0},
    '{     5,     -5, 1'b0, 1'b1, corr_t'(-Q_ONE), 1'b1}
  };

  logic clk = 1'b0;
  logic rst_n;

  rwc_in_if  in_bus ();
  rwc_out_if out_bus ();
  rwc_cfg_if cfg_bus ();

  rolling_window_correlation u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #HALF_PERIOD clk = ~clk;

  // predictor state
  logic [CFG_W-1:0] window_reg = 6'd5;
  sample_t          hist_x [MAX_WINDOW];
  sample_t          hist_y [MAX_WINDOW];
  longint           sum_x = 0, sum_y = 0, sum_xy = 0, sum_xx = 0, sum_yy = 0;
  int unsigned      taken = 0, next_slot = 0;

  corr_result_t awaited_correlations [$];
  int           mismatch_count = 0;
  bit           offering = 1'b0;
  bit           steady_flow = 1'b0;
  int           hold_request = 0;

  series_shape_e shape = MIX_RANDOM;
  sample_t       flat_level = '0;
  bit            mirror = 1'b0;

  function automatic int unsigned span_of_window(input logic [CFG_W-1:0] len);
    if (len < 2) return 2;
    if (len > MAX_WINDOW) return MAX_WINDOW;
    return len;
  endfunction

  function automatic void clear_sums();
    sum_x = 0;
    sum_y = 0;
    sum_xy = 0;
    sum_xx = 0;
    sum_yy = 0;
    taken = 0;
    next_slot = 0;
  endfunction

  // slide one pair into the window and work out the correlation it gives
  function automatic corr_result_t advance_window(input sample_t xs, input sample_t ys,
                                                  input logic start);
    int unsigned  n;
    int           b;
    longint       old_x, old_y, cov, var_x, var_y;
    logic [127:0] radicand;
    logic [63:0]  root, trial, mag, quot;
    corr_result_t res;
    n = span_of_window(window_reg);
    if (start) clear_sums();
    if (next_slot >= n) next_slot = 0;
    // evict the oldest pair once the window is full
    if (taken >= n) begin
      old_x = hist_x[next_slot];
      old_y = hist_y[next_slot];
      sum_x -= old_x;
      sum_y -= old_y;
      sum_xy -= old_x * old_y;
      sum_xx -= old_x * old_x;
      sum_yy -= old_y * old_y;
    end
    hist_x[next_slot] = xs;
    hist_y[next_slot] = ys;
    sum_x += longint'(xs);
    sum_y += longint'(ys);
    sum_xy += longint'(xs) * longint'(ys);
    sum_xx += longint'(xs) * longint'(xs);
    sum_yy += longint'(ys) * longint'(ys);
    next_slot = (next_slot + 1 >= n) ? 0 : next_slot + 1;
    if (taken < n) taken++;
    res.window_full = (taken >= n);
    res.correlation = '0;
    if (res.window_full) begin
      cov   = longint'(n) * sum_xy - sum_x * sum_y;
      var_x = longint'(n) * sum_xx - sum_x * sum_x;
      var_y = longint'(n) * sum_yy - sum_y * sum_y;
      if (var_x > 0 && var_y > 0) begin
        radicand = {64'd0, var_x} * {64'd0, var_y};
        // floor square root, one bit at a time from the top
        root = '0;
        for (b = 63; b >= 0; b--) begin
          trial = root | (64'd1 << b);
          if ({64'd0, trial} * {64'd0, trial} <= radicand) root = trial;
        end
        if (root != 0) begin
          mag  = (cov < 0) ? -cov : cov;
          quot = (mag << 14) / root;
          if (quot > Q_ONE) quot = Q_ONE;
          res.correlation = (cov < 0) ? -corr_t'(quot) : corr_t'(quot);
        end
      end
    end
    return res;
  endfunction

  // offer one pair, wait for its transfer, queue what it should give
  task automatic send_pair(input sample_t xs, input sample_t ys, input logic start,
                           input logic use_known, input corr_t known_corr,
                           input logic known_full);
    int           gap;
    corr_result_t predicted;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      if (offering) begin
        in_bus.valid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.x_sample     <= xs;
    in_bus.y_sample     <= ys;
    in_bus.series_start <= start;
    offering = 1'b1;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    predicted = advance_window(xs, ys, start);
    if (use_known) begin
      predicted.correlation = known_corr;
      predicted.window_full = known_full;
    end
    awaited_correlations = {awaited_correlations, predicted};
  endtask

  // stop offering and wait until every queued result is back
  task automatic drain_results();
    if (offering) begin
      in_bus.valid <= 1'b0;
      offering = 1'b0;
    end
    while (awaited_correlations.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] len);
    cfg_bus.window_length <= len;
    cfg_bus.valid         <= 1'b1;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    cfg_bus.valid <= 1'b0;
    // any write restarts the series
    window_reg = len;
    clear_sums();
  endtask

  // random series of assorted shapes, restarted now and then
  task automatic run_random(input int count);
    int unsigned n;
    int          k;
    logic        start;
    sample_t     xs, ys;
    n = span_of_window(window_reg);
    for (k = 0; k < count; k++) begin
      start = (k == 0) || ($urandom_range(0, 4 * n) == 0);
      if (start) begin
        shape      = series_shape_e'($urandom_range(MIX_RANDOM, MIX_RAILS));
        flat_level = sample_t'($urandom);
        mirror     = $urandom_range(0, 1);
      end
      case (shape)
        MIX_TRACKING: begin
          xs = sample_t'($urandom);
          ys = xs + sample_t'(int'($urandom_range(0, 16)) - 8);
          if (mirror) ys = -ys;
        end
        MIX_FLAT_X: begin
          xs = flat_level;
          ys = sample_t'($urandom);
        end
        MIX_FLAT_Y: begin
          xs = sample_t'($urandom);
          ys = flat_level;
        end
        MIX_TINY: begin
          xs = sample_t'(int'($urandom_range(0, 6)) - 3);
          ys = sample_t'(int'($urandom_range(0, 6)) - 3);
        end
        MIX_RAILS: begin
          xs = $urandom_range(0, 1) ? sample_t'(32767) : sample_t'(-32768);
          ys = $urandom_range(0, 1) ? sample_t'(32767) : sample_t'(-32768);
        end
        default: begin
          xs = sample_t'($urandom);
          ys = sample_t'($urandom);
        end
      endcase
      send_pair(xs, ys, start, 1'b0, '0, 1'b0);
    end
  endtask

  // stimulus
  initial begin : stimulus
    int               r;
    int               phase_id;
    logic [CFG_W-1:0] len;
    rst_n                 <= 1'b0;
    in_bus.valid          <= 1'b0;
    in_bus.x_sample       <= '0;
    in_bus.y_sample       <= '0;
    in_bus.series_start   <= 1'b0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.window_length <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows at the reset window length
    for (r = 0; r < DIRECTED_COUNT; r++) begin
      send_pair(DIRECTED_ROWS[r].x, DIRECTED_ROWS[r].y, DIRECTED_ROWS[r].start,
                DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].corr, DIRECTED_ROWS[r].full);
    end
    run_random(RANDOM_PER_PHASE);

    // one phase per window length, written while the block is idle
    for (phase_id = 0; phase_id < LISTED_PHASES + EXTRA_PHASES; phase_id++) begin
      drain_results();
      len = (phase_id < LISTED_PHASES) ? PHASE_WINDOWS[phase_id]
                                       : CFG_W'($urandom_range(0, 63));
      write_window(len);
      steady_flow = (phase_id == 2 || phase_id == 5);
      if (phase_id == HOLD_PHASE) hold_request = HOLD_CYCLES;
      run_random(RANDOM_PER_PHASE);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // result receiver with random stalls and one long hold-off
  initial begin : result_sink
    int pause;
    int held;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request > 0) begin
        held = hold_request;
        hold_request = 0;
        out_bus.ready <= 1'b0;
        repeat (held) @(posedge clk);
      end
      pause = steady_flow ? 0 : $urandom_range(0, 3);
      if (pause > 0) begin
        out_bus.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    corr_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (awaited_correlations.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual corr %0d full %0b",
                 $time, out_bus.correlation, out_bus.window_full);
        mismatch_count++;
      end else begin
        want = awaited_correlations.pop_front();
        if (want.correlation !== out_bus.correlation ||
            want.window_full !== out_bus.window_full) begin
          $display(
            "%0t ns: result mismatch, expected corr %0d full %0b, actual corr %0d full %0b",
            $time, want.correlation, want.window_full,
            out_bus.correlation, out_bus.window_full);
          mismatch_count++;
        end
      end
    end
  end

  // hard stop if the run hangs
  initial begin : watchdog
    #RUN_LIMIT_NS;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== rolling_window_correlation.f =====
design/rwc_pkg.sv
design/rwc_if.sv
design/rwc_ram.sv
design/rwc_mul.sv
design/rwc_cmpsub.sv
design/rolling_window_correlation.sv
test/testbench.sv
